/* rtl/core/byte_ring_buffer_macros.svh */
// assertion macros shared by the byte ring buffer rtl
// expects aclk and aresetn in the scope of each use
`ifndef BYTE_RING_BUFFER_MACROS_SVH
`define BYTE_RING_BUFFER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, checked out of reset
`define BRB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("byte ring buffer check failed");
// next-cycle implication, checked out of reset
`define BRB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("byte ring buffer check failed");
`else
`define BRB_ASSERT_NOW(label, ante, cons)
`define BRB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* rtl/core/brb_pkg.sv */
// shared types and constants for the byte ring buffer
// used by the queue, front end, back end and top of the block, no dependencies
package brb_pkg;

    // default ring depth
    localparam int MAX_SLOTS_DEFAULT = 256;
    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register widths and reset values
    localparam int BSZ_W = 9;
    localparam logic [BSZ_W-1:0] BSZ_RESET = 9'd256;
    localparam logic EN_RESET = 1'b1;

    // register indexes on the apb port
    localparam logic REG_BUFFER_SIZE = 1'b0;
    localparam logic REG_ENABLED = 1'b1;

    // item operation codes
    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_QUERY = 2'd3
    } func_t;

    // memory action the back end carries out
    typedef enum logic [1:0] {
        RAM_NONE  = 2'd0,
        RAM_WRITE = 2'd1,
        RAM_READ  = 2'd2
    } ram_op_t;

    // classified item handed from front to back
    typedef struct packed {
        ram_op_t     op;
        logic [7:0]  wbyte;
        logic        accepted;
        logic [7:0]  data_count;
        logic [7:0]  space_count;
        logic [15:0] overflow;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

endpackage

/* rtl/core/brb_ram.sv */
// generic single-port ram with registered read
// no dependencies
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and read register, read data holds until the next read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/brb_queue.sv */
// short register queue between the front and back of the ring buffer
// depends on brb_pkg for its default depth
module brb_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = brb_pkg::QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [IDX_W-1:0] wr_idx_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full = (cnt_reg == CNT_W'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign head = slot_reg[rd_idx_reg];

    // index wrap helper
    function automatic logic [IDX_W-1:0] bump(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] r;
        if (idx == IDX_W'(DEPTH - 1)) r = '0;
        else r = idx + IDX_W'(1);
        return r;
    endfunction

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_idx_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_idx_reg <= bump(wr_idx_reg);
            end
            if (pop) begin
                rd_idx_reg <= bump(rd_idx_reg);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* rtl/core/brb_front.sv */
// front end: accepts items, keeps pointers, count and overflow, classifies
// depends on brb_pkg and byte_ring_buffer_macros.svh
`include "byte_ring_buffer_macros.svh"

module brb_front #(
    parameter int MAX_SLOTS = brb_pkg::MAX_SLOTS_DEFAULT,
    parameter int PTR_W = $clog2(MAX_SLOTS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic [brb_pkg::BSZ_W-1:0] buffer_size,
    input  logic                      enabled,
    input  logic                      reinit,
    // item input
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [1:0]                s_func,
    input  logic [7:0]                s_write_byte,
    input  logic [15:0]               s_bytes_remaining,
    // queue side
    output logic                      push,
    output brb_pkg::desc_t            push_desc,
    output logic [PTR_W-1:0]          push_addr,
    input  logic                      queue_full
);

    localparam int SW = PTR_W + 1;

    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [SW-1:0]    cnt_reg, cnt_next;
    logic [15:0]      ovf_reg, ovf_next;
    logic [31:0]      s_wide;
    logic [SW-1:0]    slots;
    logic [SW-1:0]    cap;
    logic             full, empty;
    logic [31:0]      cnt_w, space_w;
    brb_pkg::func_t   func;

    assign s_tready = !queue_full;
    assign push = s_tvalid && s_tready;
    assign func = brb_pkg::func_t'(s_func);

    // slots in use, clamped to the supported range
    always_comb begin
        if (buffer_size < brb_pkg::BSZ_W'(2)) begin
            s_wide = 32'd2;
        end else if ({23'd0, buffer_size} > 32'(MAX_SLOTS)) begin
            s_wide = 32'(MAX_SLOTS);
        end else begin
            s_wide = {23'd0, buffer_size};
        end
    end
    assign slots = s_wide[SW-1:0];
    assign cap = slots - SW'(1);
    assign full = (cnt_reg == cap);
    assign empty = (cnt_reg == '0);

    // pointer advance with wrap at the slot count
    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [SW-1:0] s);
        logic [SW-1:0] n;
        n = {1'b0, p} + SW'(1);
        if (n >= s) n = '0;
        return n[PTR_W-1:0];
    endfunction

    // classify the item and work out the next state
    always_comb begin
        wp_next = wp_reg;
        rp_next = rp_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        push_desc = '0;
        push_desc.op = brb_pkg::RAM_NONE;
        push_desc.wbyte = s_write_byte;
        push_addr = wp_reg;
        case (func)
            brb_pkg::FUNC_WRITE: begin
                if (enabled && !full) begin
                    push_desc.op = brb_pkg::RAM_WRITE;
                    push_desc.accepted = 1'b1;
                    wp_next = advance(wp_reg, slots);
                    cnt_next = cnt_reg + SW'(1);
                end else if (enabled) begin
                    ovf_next = s_bytes_remaining;
                end
            end
            brb_pkg::FUNC_READ: begin
                push_addr = rp_reg;
                if (enabled && !empty) begin
                    push_desc.op = brb_pkg::RAM_READ;
                    push_desc.accepted = 1'b1;
                    rp_next = advance(rp_reg, slots);
                    cnt_next = cnt_reg - SW'(1);
                end
            end
            brb_pkg::FUNC_CLEAR: begin
                wp_next = '0;
                rp_next = '0;
                cnt_next = '0;
                ovf_next = '0;
            end
            default: begin
            end
        endcase
        cnt_w = 32'(cnt_next);
        space_w = 32'(cap - cnt_next);
        push_desc.data_count = cnt_w[7:0];
        push_desc.space_count = space_w[7:0];
        push_desc.overflow = ovf_next;
    end

    // ring state
    always_ff @(posedge aclk) begin
        if (!aresetn || reinit) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= '0;
        end else if (push) begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    `BRB_ASSERT_NOW(a_count_in_range, 1'b1, cnt_reg <= cap)
    `BRB_ASSERT_NEXT(a_write_grows, push && !reinit && push_desc.op == brb_pkg::RAM_WRITE, cnt_reg == $past(cnt_reg) + SW'(1))
    `BRB_ASSERT_NEXT(a_read_shrinks, push && !reinit && push_desc.op == brb_pkg::RAM_READ, cnt_reg == $past(cnt_reg) - SW'(1))

endmodule

/* rtl/core/brb_back.sv */
// back end: runs ring memory accesses in order and registers the results
// depends on brb_pkg, brb_ram and byte_ring_buffer_macros.svh
`include "byte_ring_buffer_macros.svh"

module brb_back #(
    parameter int MAX_SLOTS = brb_pkg::MAX_SLOTS_DEFAULT,
    parameter int PTR_W = $clog2(MAX_SLOTS)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // queue side
    input  logic                              q_valid,
    input  brb_pkg::desc_t                    q_desc,
    input  logic [PTR_W-1:0]                  q_addr,
    output logic                              q_pop,
    // result output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [brb_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                              p1_v_reg;
    brb_pkg::desc_t                    p1_desc_reg;
    logic                              p1_adv;
    logic                              out_v_reg;
    logic [brb_pkg::M_TDATA_W-1:0]     out_data_reg;
    logic [brb_pkg::M_TDATA_W-1:0]     out_data_next;
    logic [7:0]                        ram_rdata;
    logic [7:0]                        rbyte;

    assign p1_adv = p1_v_reg && (!out_v_reg || m_tready);
    assign q_pop = q_valid && (!p1_v_reg || p1_adv);

    // ring storage, accessed when an item leaves the queue
    brb_ram #(
        .WIDTH (8),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (q_pop && q_desc.op == brb_pkg::RAM_WRITE),
        .re    (q_pop && q_desc.op == brb_pkg::RAM_READ),
        .addr  (q_addr),
        .wdata (q_desc.wbyte),
        .rdata (ram_rdata)
    );

    // result word: read byte, accepted, data count, space count, overflow
    always_comb begin
        rbyte = (p1_desc_reg.op == brb_pkg::RAM_READ) ? ram_rdata : 8'd0;
        out_data_next = {7'd0, p1_desc_reg.overflow, p1_desc_reg.space_count,
                         p1_desc_reg.data_count, p1_desc_reg.accepted, rbyte};
    end

    // access stage and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                p1_v_reg <= 1'b1;
            end else if (p1_adv) begin
                p1_v_reg <= 1'b0;
            end
            if (p1_adv) begin
                out_v_reg <= 1'b1;
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            p1_desc_reg <= q_desc;
        end
        if (p1_adv) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = out_data_reg;

    `BRB_ASSERT_NEXT(a_stage_to_output, p1_adv, out_v_reg)
    `BRB_ASSERT_NEXT(a_pop_fills_stage, q_pop, p1_v_reg)
    `BRB_ASSERT_NOW(a_no_access_when_idle, !q_valid, !q_pop)

endmodule

/* rtl/core/byte_ring_buffer.sv */
// byte ring buffer: one byte operation per item, one result per item.
// Sustained rate is one item per clock while the queue is not full. An item
// enters the queue at the accepting edge; the back end then does its access
// to the single-port ring memory, which has a registered read, and then
// loads its result into the output register. The front end keeps the pointers,
// byte count and overflow value, so a stalled result side fills the
// four-entry queue before s_tready drops. No clearing pass is needed after
// reset: only written slots are ever read. Registers on the apb port:
// 0x0 buffer_size, 0x4 enabled; writing buffer_size also empties the ring and
// clears the overflow value.
// depends on brb_pkg, brb_queue, brb_front, brb_back

module byte_ring_buffer #(
    parameter int MAX_SLOTS = brb_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // apb configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // item input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] write_byte, [23:8] bytes_remaining
    input  logic [brb_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [1:0]                    s_tuser,
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] read_byte, [8] accepted, [16:9] data_count, [24:17] space_count,
    // [40:25] overflow_count, [47:41] zero
    output logic [brb_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PTR_W = $clog2(MAX_SLOTS);
    localparam int QW = PTR_W + brb_pkg::DESC_W;

    logic [brb_pkg::BSZ_W-1:0] bsz_reg;
    logic                      en_reg;
    logic                      cfg_wr;
    logic                      reg_idx;
    logic                      reinit;
    logic                      push, pop, q_full, q_valid;
    brb_pkg::desc_t            push_desc, q_desc;
    logic [PTR_W-1:0]          push_addr, q_addr;
    logic [QW-1:0]             q_head;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];
    assign reinit = cfg_wr && (reg_idx == brb_pkg::REG_BUFFER_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bsz_reg <= brb_pkg::BSZ_RESET;
            en_reg <= brb_pkg::EN_RESET;
        end else if (cfg_wr) begin
            if (reg_idx == brb_pkg::REG_BUFFER_SIZE) begin
                bsz_reg <= pwdata[brb_pkg::BSZ_W-1:0];
            end else begin
                en_reg <= pwdata[0];
            end
        end
    end

    assign prdata = (reg_idx == brb_pkg::REG_ENABLED) ? {31'd0, en_reg}
                                                       : {23'd0, bsz_reg};

    // front end
    brb_front #(
        .MAX_SLOTS (MAX_SLOTS),
        .PTR_W     (PTR_W)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .buffer_size       (bsz_reg),
        .enabled           (en_reg),
        .reinit            (reinit),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_func            (s_tuser),
        .s_write_byte      (s_tdata[7:0]),
        .s_bytes_remaining (s_tdata[23:8]),
        .push              (push),
        .push_desc         (push_desc),
        .push_addr         (push_addr),
        .queue_full        (q_full)
    );

    // queue between front and back
    brb_queue #(
        .WIDTH (QW),
        .DEPTH (brb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_addr, push_desc}),
        .full      (q_full),
        .pop       (pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    assign q_desc = q_head[brb_pkg::DESC_W-1:0];
    assign q_addr = q_head[QW-1:brb_pkg::DESC_W];

    // back end
    brb_back #(
        .MAX_SLOTS (MAX_SLOTS),
        .PTR_W     (PTR_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_desc   (q_desc),
        .q_addr   (q_addr),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* verif/tb_byte_ring_buffer.sv */
// testbench for byte_ring_buffer: directed and random byte operations with a
// cycle-level ring predictor, random stalls on both item channels, apb setup
// depends on brb_pkg and the byte_ring_buffer rtl

module tb_byte_ring_buffer;

    import brb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    // expected contents of one result item
    typedef struct {
        logic [7:0]  read_byte;
        logic        accepted;
        logic [7:0]  data_count;
        logic [7:0]  space_count;
        logic [15:0] overflow_count;
    } ring_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [7:0] write_byte, [23:8] bytes_remaining
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // [1:0] func
    logic [1:0]  s_tuser = FUNC_QUERY;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [7:0] read_byte, [8] accepted, [16:9] data_count, [24:17] space_count,
    // [40:25] overflow_count, [47:41] zero
    logic [M_TDATA_W-1:0] m_tdata;

    // predictor copy of the ring and its registers
    logic [8:0]   ring_size_reg = BSZ_RESET;
    logic         ring_enabled = EN_RESET;
    int unsigned  wr_ptr = 0;
    int unsigned  rd_ptr = 0;
    logic [15:0]  overflow_value = '0;
    logic [7:0]   ring_bytes [256];

    ring_result_t expected_results [$];
    int           fail_count = 0;
    int           cycle_count = 0;
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           hold_cnt = 0;

    byte_ring_buffer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // slots actually used, size register clamped to 2..256
    function automatic int unsigned ring_slots();
        if (ring_size_reg < 2) return 2;
        if (ring_size_reg > 256) return 256;
        return ring_size_reg;
    endfunction

    function automatic int unsigned ring_held(input int unsigned slots);
        if (rd_ptr <= wr_ptr) return wr_ptr - rd_ptr;
        return wr_ptr + slots - rd_ptr;
    endfunction

    // register write as seen on the apb port
    function automatic void apply_register(input logic [2:0] addr, input logic [31:0] value);
        if (addr[2] == REG_BUFFER_SIZE) begin
            ring_size_reg = value[8:0];
            wr_ptr = 0;
            rd_ptr = 0;
            overflow_value = '0;
        end else begin
            ring_enabled = value[0];
        end
    endfunction

    // apply one byte operation to the predictor and return its result
    function automatic ring_result_t predict_ring_op(input func_t op, input logic [7:0] wbyte,
                                                     input logic [15:0] remaining);
        ring_result_t res;
        int unsigned  slots;
        int unsigned  held;
        slots = ring_slots();
        res.read_byte = '0;
        res.accepted = 1'b0;
        case (op)
            FUNC_WRITE: begin
                if (ring_enabled) begin
                    if (slots - ring_held(slots) - 1 == 0) begin
                        overflow_value = remaining;
                    end else begin
                        ring_bytes[wr_ptr] = wbyte;
                        wr_ptr = (wr_ptr + 1 >= slots) ? 0 : wr_ptr + 1;
                        res.accepted = 1'b1;
                    end
                end
            end
            FUNC_READ: begin
                if (ring_enabled && ring_held(slots) != 0) begin
                    res.read_byte = ring_bytes[rd_ptr];
                    rd_ptr = (rd_ptr + 1 >= slots) ? 0 : rd_ptr + 1;
                    res.accepted = 1'b1;
                end
            end
            FUNC_CLEAR: begin
                wr_ptr = 0;
                rd_ptr = 0;
                overflow_value = '0;
            end
            default: begin
            end
        endcase
        held = ring_held(slots);
        res.data_count = 8'(held);
        res.space_count = 8'(slots - held - 1);
        res.overflow_count = overflow_value;
        return res;
    endfunction

    // compare one result item with the oldest expectation
    task automatic check_result(input logic [M_TDATA_W-1:0] got);
        ring_result_t want;
        if (expected_results.size() == 0) begin
            $error("result item with no expectation pending: %h", got);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got[7:0] !== want.read_byte) begin
            $error("read_byte: expected %0d, got %0d", want.read_byte, got[7:0]);
            fail_count++;
        end
        if (got[8] !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got[8]);
            fail_count++;
        end
        if (got[16:9] !== want.data_count) begin
            $error("data_count: expected %0d, got %0d", want.data_count, got[16:9]);
            fail_count++;
        end
        if (got[24:17] !== want.space_count) begin
            $error("space_count: expected %0d, got %0d", want.space_count, got[24:17]);
            fail_count++;
        end
        if (got[40:25] !== want.overflow_count) begin
            $error("overflow_count: expected %0d, got %0d", want.overflow_count, got[40:25]);
            fail_count++;
        end
    endtask

    // register writes, accepted items and result items, in that order per edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (psel && penable && pwrite && pready)
                apply_register(paddr, pwdata);
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_ring_op(func_t'(s_tuser), s_tdata[7:0],
                                                           s_tdata[23:8]));
            if (m_tvalid && m_tready)
                check_result(m_tdata);
        end
    end

    // result side backpressure: ready bursts broken by short and rare long stalls
    always @(posedge aclk) begin
        if (hold_cnt != 0) begin
            hold_cnt--;
        end else if (m_tready) begin
            if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                m_tready <= 1'b0;
                hold_cnt = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 2);
            end else begin
                hold_cnt = $urandom_range(0, 20);
            end
        end else begin
            m_tready <= 1'b1;
            hold_cnt = $urandom_range(0, 20);
        end
    end

    // present one item, optionally after an idle gap, and wait for acceptance
    task automatic send_item(input func_t op, input logic [7:0] wbyte,
                             input logic [15:0] remaining);
        int gap;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
            gap = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {remaining, wbyte};
        s_tuser <= op;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_register(input logic idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [15:0] random_remaining();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // query and read on the ring as it comes out of reset
    task automatic test_reset_state();
        send_item(FUNC_QUERY, 8'h00, 16'd1);
        send_item(FUNC_READ, 8'hFF, 16'hFFFF);
    endtask

    // extreme byte and count values through the full-size ring
    task automatic test_field_extremes();
        send_item(FUNC_WRITE, 8'h00, 16'd1);
        send_item(FUNC_WRITE, 8'hFF, 16'hFFFF);
        send_item(FUNC_WRITE, 8'hA5, 16'd0);
        send_item(FUNC_QUERY, 8'h5A, 16'd0);
        send_item(FUNC_READ, 8'h00, 16'd0);
        send_item(FUNC_READ, 8'h00, 16'd0);
        send_item(FUNC_READ, 8'h00, 16'd0);
        send_item(FUNC_READ, 8'h00, 16'd0);
    endtask

    // full ring refuses writes and records the remaining count, clear resets it
    task automatic test_overflow();
        drain_results();
        write_register(REG_BUFFER_SIZE, 32'd2);
        send_item(FUNC_WRITE, 8'h3C, 16'd7);
        send_item(FUNC_WRITE, 8'hC3, 16'hFFFF);
        send_item(FUNC_WRITE, 8'h11, 16'd0);
        send_item(FUNC_WRITE, 8'h22, 16'h1234);
        send_item(FUNC_READ, 8'h00, 16'd1);
        send_item(FUNC_WRITE, 8'h44, 16'd9);
        send_item(FUNC_CLEAR, 8'h00, 16'd1);
        send_item(FUNC_QUERY, 8'h00, 16'd1);
    endtask

    // disabled ring refuses reads and writes, clear and query still work
    task automatic test_disabled();
        send_item(FUNC_WRITE, 8'h81, 16'd3);
        drain_results();
        write_register(REG_ENABLED, 32'd0);
        send_item(FUNC_WRITE, 8'h7E, 16'd5);
        send_item(FUNC_READ, 8'h00, 16'd1);
        send_item(FUNC_QUERY, 8'h00, 16'd1);
        send_item(FUNC_CLEAR, 8'h00, 16'd1);
        drain_results();
        write_register(REG_ENABLED, 32'hFFFF_FFFF);
        send_item(FUNC_READ, 8'h00, 16'd1);
    endtask

    // sizes below 2 and above 256 clamp, a size write empties the ring
    task automatic test_size_clamp();
        logic [8:0] sizes [3];
        sizes = '{9'd0, 9'd1, 9'd511};
        foreach (sizes[i]) begin
            drain_results();
            write_register(REG_BUFFER_SIZE, {23'h7FFFFF, sizes[i]});
            send_item(FUNC_WRITE, 8'($urandom), 16'd2);
            send_item(FUNC_WRITE, 8'($urandom), 16'd1);
        end
        drain_results();
        write_register(REG_BUFFER_SIZE, 32'd3);
        send_item(FUNC_QUERY, 8'h00, 16'd1);
    endtask

    // fill the 256-slot ring past capacity, then empty it past zero
    task automatic test_full_ring();
        drain_results();
        write_register(REG_BUFFER_SIZE, 32'd256);
        gap_pct = 15;
        stall_pct = 20;
        repeat (258) send_item(FUNC_WRITE, 8'($urandom), random_remaining());
        stall_pct = 0;
        repeat (257) send_item(FUNC_READ, 8'($urandom), random_remaining());
    endtask

    // phases of random operations over several sizes and idle patterns
    task automatic test_random_mix();
        int         write_pct;
        int         r;
        logic [8:0] size;
        func_t      op;
        for (int phase = 0; phase < 9; phase++) begin
            drain_results();
            case (phase)
                0: size = 9'd3;
                1: size = 9'd17;
                2: size = 9'd2;
                3: size = 9'd255;
                4: size = 9'd300;
                5: size = 9'd128;
                6: size = 9'd1;
                default: size = 9'($urandom_range(2, 40));
            endcase
            write_register(REG_BUFFER_SIZE, ($urandom & 32'hFFFF_FE00) | 32'(size));
            write_register(REG_ENABLED, ($urandom_range(7) == 0) ? 32'd0 : 32'd1);
            case ($urandom_range(3))
                0: write_pct = 30;
                1: write_pct = 47;
                2: write_pct = 70;
                default: write_pct = 90;
            endcase
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 20;
                default: gap_pct = 50;
            endcase
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 30;
                default: stall_pct = 70;
            endcase
            repeat (70) begin
                r = $urandom_range(99);
                if (r < 2) op = FUNC_CLEAR;
                else if (r < 6) op = FUNC_QUERY;
                else if (r < 6 + write_pct) op = FUNC_WRITE;
                else op = FUNC_READ;
                send_item(op, 8'($urandom), random_remaining());
            end
        end
        drain_results();
        write_register(REG_ENABLED, 32'd1);
    endtask

    initial begin
        foreach (ring_bytes[i]) ring_bytes[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_field_extremes();
        test_overflow();
        test_disabled();
        test_size_clamp();
        test_full_ring();
        test_random_mix();
        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
